### design/edsim_pkg.sv
// shared types and constants for the edit distance similarity unit
`timescale 1ns / 1ps
`default_nettype none

package edsim_pkg;

   localparam int KIND_W   = 2;
   localparam int CH_W     = 8;
   localparam int DIST_W   = 7;
   localparam int SIM_W    = 10;
   localparam int SIM_FULL = 1000;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

   // operation carried by a token along the cell chain
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CHAR,
      OP_FIN
   } op_type;

   typedef struct packed {
      logic   vld;
      op_type op;
   } tok_ctl_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

### design/edsim_cell.sv
// one cell of the edit distance chain: one stored character and one row entry
`timescale 1ns / 1ps
`default_nettype none

module edsim_cell #(
   parameter int DW    = 7,
   parameter int INDEX = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire edsim_pkg::tok_ctl_type up_ctl,
   input  wire logic [edsim_pkg::CH_W-1:0] up_ch,
   input  wire logic [DW-1:0]          up_left,
   input  wire logic [DW-1:0]          up_diag,
   output      edsim_pkg::tok_ctl_type dn_ctl,
   output      logic [edsim_pkg::CH_W-1:0] dn_ch,
   output      logic [DW-1:0]          dn_left,
   output      logic [DW-1:0]          dn_diag
);
   import edsim_pkg::*;

   logic            valid_ff, valid_in;
   logic [CH_W-1:0] char_ff, char_in;
   logic [DW-1:0]   dp_ff, dp_in;

   tok_ctl_type     dn_ctl_ff, dn_ctl_in;
   logic [CH_W-1:0] dn_ch_ff, dn_ch_in;
   logic [DW-1:0]   dn_left_ff, dn_left_in;
   logic [DW-1:0]   dn_diag_ff, dn_diag_in;

   logic            cost;
   logic [DW:0]     up_inc, left_inc, diag_cost, min_a, best;

   // min of deletion, insertion and substitution
   always_comb begin
      cost      = (char_ff != up_ch);
      up_inc    = {1'b0, dp_ff} + (DW+1)'(1);
      left_inc  = {1'b0, up_left} + (DW+1)'(1);
      diag_cost = {1'b0, up_diag} + {{DW{1'b0}}, cost};
      min_a     = (up_inc < left_inc) ? up_inc : left_inc;
      best      = (min_a < diag_cost) ? min_a : diag_cost;
   end

   always_comb begin
      valid_in   = valid_ff;
      char_in    = char_ff;
      dp_in      = dp_ff;
      dn_ctl_in  = up_ctl;
      dn_ch_in   = up_ch;
      dn_left_in = up_left;
      dn_diag_in = up_diag;
      if (up_ctl.vld) begin
         case (up_ctl.op)
            OP_LOAD: begin
               // first empty cell takes the character and consumes the token
               if (!valid_ff) begin
                  valid_in      = 1'b1;
                  char_in       = up_ch;
                  dn_ctl_in.vld = 1'b0;
               end
            end
            OP_CHAR: begin
               if (valid_ff) begin
                  dp_in      = best[DW-1:0];
                  dn_left_in = best[DW-1:0];
                  dn_diag_in = dp_ff;
               end
            end
            OP_FIN: begin
               // last occupied cell leaves its entry as the distance
               if (valid_ff) begin
                  dn_left_in = dp_ff;
               end
               valid_in = 1'b0;
               dp_in    = DW'(INDEX);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dp_ff     <= DW'(INDEX);
         dn_ctl_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         dp_ff     <= dp_in;
         dn_ctl_ff <= dn_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      dn_ch_ff   <= dn_ch_in;
      dn_left_ff <= dn_left_in;
      dn_diag_ff <= dn_diag_in;
   end

   assign dn_ctl  = dn_ctl_ff;
   assign dn_ch   = dn_ch_ff;
   assign dn_left = dn_left_ff;
   assign dn_diag = dn_diag_ff;

endmodule

`default_nettype wire

### design/edsim_div.sv
// restoring divider, one quotient bit per cycle, for the similarity score
`timescale 1ns / 1ps
`default_nettype none

module edsim_div #(
   parameter int NW    = 17,
   parameter int DEN_W = 7
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [NW-1:0]                   num,
   input  wire logic [DEN_W-1:0]                den,
   output      logic                            done,
   output      logic [edsim_pkg::SIM_W-1:0]     quo
);
   import edsim_pkg::*;

   localparam int CW = $clog2(NW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NW-1:0]    quo_ff, quo_in;

   logic [DEN_W:0]   trial, diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff[SIM_W-1:0];

endmodule

`default_nettype wire

### design/edit_distance_similarity_unit.sv
// top level of the edit distance similarity unit: head stage, cell chain, divider
`timescale 1ns / 1ps
`default_nettype none

// Levenshtein distance between two byte strings of up to MAX_LEN characters
// each. Send the second string first as kind 0 requests, then the first
// string as kind 1 requests, then a kind 2 finish request, which returns one
// response with the distance, floor(1000*(m-d)/m) with m the longer length
// (1000 when both are empty) and a flag telling that characters beyond
// MAX_LEN were dropped. The finish also clears both strings for the next pair.
// The row of distances lives in a chain of MAX_LEN cells; cell k stores the
// k-th character of the second string and row entry k. Each first-string
// character travels down the chain one cell per cycle as a wavefront, so
// character and load requests are taken one per cycle, back to back. A finish
// request waits for the chain to drain: it walks the head stage and the cells,
// then runs through the bit-serial divider, then loads the response register;
// no request is taken in that time.
// While a response waits to be taken, character and load requests are still
// accepted; a new finish is accepted once the response leaves. Kind 3 and
// second-string characters sent after the first string has begun are ignored.

module edit_distance_similarity_unit #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [edsim_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [edsim_pkg::CH_W-1:0]         req_ch,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [edsim_pkg::DIST_W-1:0]       rsp_distance,
   output      logic [edsim_pkg::SIM_W-1:0]        rsp_similarity_permille,
   output      logic                               rsp_overflow
);
   import edsim_pkg::*;

   // width of lengths and row entries, and of the score numerator
   localparam int DW = $clog2(MAX_LEN + 1);
   localparam int NW = DW + SIM_W;

   // request handshake and state machine
   state_type state_ff, state_in;
   logic      req_fire;
   logic      fin_fire;
   logic      fin_arrive;
   logic      div_start;
   logic      div_done;
   logic [SIM_W-1:0] div_quo;

   // head stage: string lengths, drop flag and the token entering the chain
   logic [DW-1:0]   first_len_ff, first_len_in;
   logic [DW-1:0]   second_len_ff, second_len_in;
   logic            ovf_seen_ff, ovf_seen_in;
   logic [DW-1:0]   fin_len_ff, fin_len_in;     // longer length at finish
   logic            fin_ovf_ff, fin_ovf_in;
   tok_ctl_type     head_ctl_ff, head_ctl_in;
   logic [CH_W-1:0] head_ch_ff, head_ch_in;
   logic [DW-1:0]   head_left_ff, head_left_in;
   logic [DW-1:0]   head_diag_ff, head_diag_in;

   // chain taps, position 0 is the head stage
   tok_ctl_type     chain_ctl  [MAX_LEN+1];
   logic [CH_W-1:0] chain_ch   [MAX_LEN+1];
   logic [DW-1:0]   chain_left [MAX_LEN+1];
   logic [DW-1:0]   chain_diag [MAX_LEN+1];

   // finish bookkeeping and response register
   logic [DW-1:0]     dist_ff, dist_in;
   logic [DW-1:0]     dist_clamp;
   logic [NW-1:0]     sim_num;
   logic [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic [SIM_W-1:0]  rsp_sim_ff, rsp_sim_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   assign req_fire   = req_valid & req_ready;
   assign fin_fire   = req_fire & (req_kind == KIND_FINISH);
   assign fin_arrive = chain_ctl[MAX_LEN].vld & (chain_ctl[MAX_LEN].op == OP_FIN);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (fin_fire) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (fin_arrive) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = fin_fire ? ST_DRAIN : ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
         end
         ST_DRAIN: begin
            div_start = fin_arrive;
         end
         ST_DIV: begin
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            // a finish needs the response register free
            req_ready = rsp_ready | (req_kind != KIND_FINISH);
         end
         default: begin
         end
      endcase
   end

   // head stage: length counters and token launch
   always_comb begin
      first_len_in     = first_len_ff;
      second_len_in    = second_len_ff;
      ovf_seen_in      = ovf_seen_ff;
      fin_len_in       = fin_len_ff;
      fin_ovf_in       = fin_ovf_ff;
      head_ctl_in.vld  = 1'b0;
      head_ctl_in.op   = OP_LOAD;
      head_ch_in       = req_ch;
      head_left_in     = first_len_ff;
      head_diag_in     = first_len_ff;
      if (req_fire) begin
         case (req_kind)
            KIND_LOAD: begin
               // ignored once the first string has started
               if (first_len_ff == '0) begin
                  if (second_len_ff == DW'(MAX_LEN)) begin
                     ovf_seen_in = 1'b1;
                  end else begin
                     second_len_in   = second_len_ff + DW'(1);
                     head_ctl_in.vld = 1'b1;
                     head_ctl_in.op  = OP_LOAD;
                  end
               end
            end
            KIND_CHAR: begin
               if (first_len_ff == DW'(MAX_LEN)) begin
                  ovf_seen_in = 1'b1;
               end else begin
                  // row entry 0 goes from i to i+1
                  first_len_in    = first_len_ff + DW'(1);
                  head_ctl_in.vld = 1'b1;
                  head_ctl_in.op  = OP_CHAR;
                  head_left_in    = first_len_ff + DW'(1);
                  head_diag_in    = first_len_ff;
               end
            end
            KIND_FINISH: begin
               // distance starts as row entry 0 in case the second string is empty
               head_ctl_in.vld = 1'b1;
               head_ctl_in.op  = OP_FIN;
               head_left_in    = first_len_ff;
               fin_len_in      = (first_len_ff > second_len_ff) ? first_len_ff
                                                                : second_len_ff;
               fin_ovf_in      = ovf_seen_ff;
               first_len_in    = '0;
               second_len_in   = '0;
               ovf_seen_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign chain_ctl[0]  = head_ctl_ff;
   assign chain_ch[0]   = head_ch_ff;
   assign chain_left[0] = head_left_ff;
   assign chain_diag[0] = head_diag_ff;

   // row of cells, cell k holds row entry k
   for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
      edsim_cell #(
         .DW    (DW),
         .INDEX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_ctl  (chain_ctl[k-1]),
         .up_ch   (chain_ch[k-1]),
         .up_left (chain_left[k-1]),
         .up_diag (chain_diag[k-1]),
         .dn_ctl  (chain_ctl[k]),
         .dn_ch   (chain_ch[k]),
         .dn_left (chain_left[k]),
         .dn_diag (chain_diag[k])
      );
   end

   // score numerator 1000*(m-d), taken by the divider as the finish leaves the chain
   always_comb begin
      dist_clamp = (chain_left[MAX_LEN] > fin_len_ff) ? fin_len_ff : chain_left[MAX_LEN];
      sim_num    = NW'(fin_len_ff - dist_clamp) * NW'(SIM_FULL);
      dist_in    = fin_arrive ? chain_left[MAX_LEN] : dist_ff;
   end

   edsim_div #(
      .NW    (NW),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sim_num),
      .den   (fin_len_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // response register, loaded when the divider finishes
   always_comb begin
      rsp_distance_in = rsp_distance_ff;
      rsp_sim_in      = rsp_sim_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      if (div_done) begin
         rsp_distance_in = DIST_W'(dist_ff);
         // both strings empty scores a full match
         rsp_sim_in      = (fin_len_ff == '0) ? SIM_W'(SIM_FULL) : div_quo;
         rsp_ovf_in      = fin_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_seen_ff   <= 1'b0;
         head_ctl_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_seen_ff   <= ovf_seen_in;
         head_ctl_ff   <= head_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_len_ff      <= fin_len_in;
      fin_ovf_ff      <= fin_ovf_in;
      head_ch_ff      <= head_ch_in;
      head_left_ff    <= head_left_in;
      head_diag_ff    <= head_diag_in;
      dist_ff         <= dist_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_sim_ff      <= rsp_sim_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   assign rsp_distance            = rsp_distance_ff;
   assign rsp_similarity_permille = rsp_sim_ff;
   assign rsp_overflow            = rsp_ovf_ff;

endmodule

`default_nettype wire

### tb/sv/edit_distance_similarity_unit_tb.sv
// testbench for the edit distance similarity unit: random and directed string pairs, checked
`timescale 1ns / 1ps

module edit_distance_similarity_unit_tb;
   import edsim_pkg::*;

   localparam int MAX_LEN = 64;
   localparam int HELD_IDX_W = $clog2(MAX_LEN);
   // kind 3 has no meaning in the block and must be dropped silently
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   // cycles without any transfer while work is outstanding before giving up
   localparam int STALL_LIMIT = 2000;
   // a finish walks the chain, runs the divider and loads the output register
   localparam int DRAIN_CYCLES = 2 * (MAX_LEN + 30);
   // length of the long receiver hold-off
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [SIM_W-1:0]  similarity;
      logic              overflow;
   } score_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = KIND_LOAD;
   logic [CH_W-1:0]     req_ch = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DIST_W-1:0]   rsp_distance;
   logic [SIM_W-1:0]    rsp_similarity_permille;
   logic                rsp_overflow;

   // predictor copy of the string pair and the distance row
   logic [CH_W-1:0]     held_str [MAX_LEN];
   logic [DIST_W-1:0]   held_len;
   logic [DIST_W-1:0]   stream_len;
   logic [DIST_W-1:0]   dist_row [MAX_LEN+1];
   logic                dropped;
   score_type           pending_scores [$];

   // flow-control knobs, in percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // receiver hold-off request, counted down by the receiver process
   int rsp_hold_left = 0;

   int requests_taken = 0;
   int scores_checked = 0;
   int scores_dropped = 0;
   int errors = 0;
   int quiet_cycles = 0;

   edit_distance_similarity_unit #(
      .MAX_LEN(MAX_LEN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_ch(req_ch),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_similarity_permille(rsp_similarity_permille),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // back to an empty pair: no strings, row entry j holds j, no drops
   function automatic void clear_pair();
      for (int j = 0; j < MAX_LEN; j++) held_str[j] = '0;
      for (int j = 0; j <= MAX_LEN; j++) dist_row[j] = DIST_W'(j);
      held_len = '0;
      stream_len = '0;
      dropped = 1'b0;
   endfunction

   // apply one accepted request to the predictor, queue a score on finish;
   // returns 0 for requests that the block ignores
   function automatic bit track_request(input logic [KIND_W-1:0] kind,
                                        input logic [CH_W-1:0] ch);
      int diag;
      int up;
      int cost;
      int best;
      int d;
      int m;
      score_type s;
      track_request = 1'b1;
      case (kind)
         KIND_LOAD: begin
            // second-string chars after the first string has begun are ignored
            if (stream_len != 0) begin
               track_request = 1'b0;
            end else if (held_len >= MAX_LEN) begin
               dropped = 1'b1;
            end else begin
               held_str[held_len[HELD_IDX_W-1:0]] = ch;
               held_len = held_len + 1'b1;
            end
         end
         KIND_CHAR: begin
            if (stream_len >= MAX_LEN) begin
               dropped = 1'b1;
            end else begin
               stream_len = stream_len + 1'b1;
               diag = dist_row[0];
               dist_row[0] = stream_len;
               for (int j = 1; j <= held_len; j++) begin
                  up = dist_row[j];
                  cost = (held_str[j-1] == ch) ? 0 : 1;
                  best = up + 1;
                  if (int'(dist_row[j-1]) + 1 < best) best = int'(dist_row[j-1]) + 1;
                  if (diag + cost < best) best = diag + cost;
                  dist_row[j] = DIST_W'(best);
                  diag = up;
               end
            end
         end
         KIND_FINISH: begin
            d = dist_row[held_len];
            m = (stream_len > held_len) ? int'(stream_len) : int'(held_len);
            s.distance = DIST_W'(d);
            s.similarity = (m == 0) ? SIM_W'(SIM_FULL) : SIM_W'((SIM_FULL * (m - d)) / m);
            s.overflow = dropped;
            pending_scores.push_back(s);
            clear_pair();
         end
         default: begin
            track_request = 1'b0;
         end
      endcase
   endfunction

   // offer one request, with random sender gaps, and wait for its handshake
   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_ch <= ch;
      do @(posedge clock); while (!req_ready);
      if (track_request(kind, ch)) requests_taken++;
   endtask

   // alpha 0 means any byte, otherwise a small alphabet starting at 'a'
   function automatic logic [CH_W-1:0] rand_char(input int alpha);
      if (alpha == 0) return CH_W'($urandom_range(255));
      return CH_W'(8'h61 + $urandom_range(alpha - 1));
   endfunction

   // mostly short strings, some long, a few around the length limit
   function automatic int rand_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85) return $urandom_range(10);
      if (pick < 95) return $urandom_range(63, 11);
      return $urandom_range(MAX_LEN + 4, MAX_LEN - 3);
   endfunction

   // one well-formed pair with random content, sometimes with junk mixed in
   task automatic run_pair();
      int n_held;
      int n_stream;
      int alpha;
      int noise;
      n_held = rand_len();
      n_stream = rand_len();
      case ($urandom_range(9))
         0, 1:    alpha = 0;
         2, 3, 4: alpha = 2;
         default: alpha = 4;
      endcase
      noise = $urandom_range(9);
      repeat (n_held) send_req(KIND_LOAD, rand_char(alpha));
      if (noise == 0) send_req(KIND_SPARE, rand_char(0));
      for (int i = 0; i < n_stream; i++) begin
         send_req(KIND_CHAR, rand_char(alpha));
         // late second-string char, must leave the row alone
         if (noise == 1 && i == 0) send_req(KIND_LOAD, rand_char(alpha));
      end
      send_req(KIND_FINISH, rand_char(0));
   endtask

   // short hand-picked pairs covering every kind and the byte extremes
   task automatic test_directed();
      // two empty strings score a full match
      send_req(KIND_FINISH, 8'hFF);
      // first string only
      send_req(KIND_CHAR, 8'h00);
      send_req(KIND_CHAR, 8'hFF);
      send_req(KIND_FINISH, 8'h00);
      // second string only
      send_req(KIND_LOAD, 8'h55);
      send_req(KIND_LOAD, 8'hAA);
      send_req(KIND_FINISH, 8'h5A);
      // one deletion, with a late load and the spare kind in between
      send_req(KIND_LOAD, 8'hFF);
      send_req(KIND_LOAD, 8'h00);
      send_req(KIND_LOAD, 8'h41);
      send_req(KIND_CHAR, 8'h00);
      send_req(KIND_LOAD, 8'h7E);
      send_req(KIND_SPARE, 8'h81);
      send_req(KIND_CHAR, 8'h41);
      send_req(KIND_FINISH, 8'h00);
      // identical strings
      send_req(KIND_LOAD, 8'h61);
      send_req(KIND_LOAD, 8'h62);
      send_req(KIND_CHAR, 8'h61);
      send_req(KIND_CHAR, 8'h62);
      send_req(KIND_FINISH, 8'h00);
   endtask

   // full-length strings and characters dropped from either string
   task automatic test_long_strings();
      // no shared characters at full length: largest possible distance
      repeat (MAX_LEN) send_req(KIND_LOAD, 8'h61);
      repeat (MAX_LEN) send_req(KIND_CHAR, 8'h62);
      send_req(KIND_FINISH, 8'h00);
      // second string too long
      repeat (MAX_LEN + 2) send_req(KIND_LOAD, rand_char(2));
      repeat (5) send_req(KIND_CHAR, rand_char(2));
      send_req(KIND_FINISH, 8'h00);
      // first string too long
      repeat (3) send_req(KIND_LOAD, rand_char(2));
      repeat (MAX_LEN + 3) send_req(KIND_CHAR, rand_char(2));
      send_req(KIND_FINISH, 8'h00);
   endtask

   // random pairs under one flow-control setting until the request quota is met
   task automatic test_random_pairs(input int idle_pct, input int stall_pct, input int quota);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = requests_taken;
      while (requests_taken - start < quota) run_pair();
   endtask

   // receiver holds off while short pairs keep coming, so a second finish
   // backs up behind the waiting response and the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (4) begin
         repeat (3) send_req(KIND_LOAD, rand_char(2));
         repeat (4) send_req(KIND_CHAR, rand_char(2));
         send_req(KIND_FINISH, rand_char(0));
      end
   endtask

   // receiver: a long hold-off when asked, random stalls otherwise
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // response checker: every taken response against the oldest prediction
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected response, distance %0d similarity %0d overflow %0d",
                     $time, rsp_distance, rsp_similarity_permille, rsp_overflow);
            errors++;
         end else begin
            want = pending_scores.pop_front();
            scores_checked++;
            if (want.overflow) scores_dropped++;
            if (rsp_distance !== want.distance) begin
               $display("%0t: distance expected %0d actual %0d",
                        $time, want.distance, rsp_distance);
               errors++;
            end
            if (rsp_similarity_permille !== want.similarity) begin
               $display("%0t: similarity expected %0d actual %0d",
                        $time, want.similarity, rsp_similarity_permille);
               errors++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0d actual %0d",
                        $time, want.overflow, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // watchdog: only counts while a request is offered or a response is owed
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (!req_valid && pending_scores.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_pair();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_strings();
      test_random_pairs(0, 0, 300);
      test_random_pairs(61, 0, 250);
      test_random_pairs(0, 61, 250);
      test_random_pairs(10, 10, 250);
      test_backpressure();
      // stimulus done: drop valid and let the last finish come out
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests, checked %0d responses (%0d with dropped chars)",
               requests_taken, scores_checked, scores_dropped);
      $display("phases: full rate, sender gaps, receiver stalls, mixed, long response hold");
      if (errors == 0 && pending_scores.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
design/edsim_pkg.sv
design/edsim_cell.sv
design/edsim_div.sv
design/edit_distance_similarity_unit.sv
tb/sv/edit_distance_similarity_unit_tb.sv
